/* rtl/unfp_pkg.sv */
// Shared types, codes and helpers for the navigation frame parser.
// No dependencies; used by every module under rtl.
package unfp_pkg;

  localparam logic [7:0] SYNC_1      = 8'hB5;
  localparam logic [7:0] SYNC_2      = 8'h62;
  localparam logic [7:0] CLASS_NAV   = 8'h01;
  localparam logic [7:0] ID_POSLLH   = 8'h02;
  localparam logic [7:0] ID_STATUS   = 8'h03;
  localparam logic [7:0] ID_SOL      = 8'h06;
  localparam logic [7:0] ID_VELNED   = 8'h12;
  localparam logic [7:0] MAX_PAYLOAD = 8'd64;
  localparam logic [7:0] FIX_3D      = 8'h03;

  localparam logic [15:0] TIMEOUT_RESET = 16'd2000;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [2:0] KIND_POSITION = 3'd0;
  localparam logic [2:0] KIND_STATUS   = 3'd1;
  localparam logic [2:0] KIND_SOLUTION = 3'd2;
  localparam logic [2:0] KIND_VELOCITY = 3'd3;
  localparam logic [2:0] KIND_CKS_ERR  = 3'd4;
  localparam logic [2:0] KIND_TIMEOUT  = 3'd5;
  localparam logic [2:0] KIND_LEN_ERR  = 3'd6;

  // Payload bytes are kept only at the offsets the decoder reads:
  // 0..11, 16..27, 36..39 and 47, packed into 29 slots.
  localparam int NUM_SLOTS = 29;

  typedef logic [4:0] slot_t;
  typedef logic [NUM_SLOTS-1:0][7:0] cap_t;

  localparam slot_t SLOT_TOW        = 5'd0;
  localparam slot_t SLOT_LON        = 5'd4;
  localparam slot_t SLOT_LAT        = 5'd8;
  localparam slot_t SLOT_STAT_FIX   = 5'd4;
  localparam slot_t SLOT_STAT_FLAGS = 5'd5;
  localparam slot_t SLOT_SOL_FIX    = 5'd10;
  localparam slot_t SLOT_SOL_FLAGS  = 5'd11;
  localparam slot_t SLOT_P16        = 5'd12;
  localparam slot_t SLOT_P20        = 5'd16;
  localparam slot_t SLOT_P24        = 5'd20;
  localparam slot_t SLOT_P36        = 5'd24;
  localparam slot_t SLOT_SATS       = 5'd28;

  typedef struct packed {
    logic  hit;
    slot_t slot;
  } slot_map_t;

  typedef struct packed {
    logic       len_err;
    logic       cks_err;
    logic       cks_ok;
    logic [7:0] msg_class;
    logic [7:0] msg_id;
  } frame_evt_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic        fix_valid;
    logic [31:0] time_of_week;
    logic [31:0] longitude;
    logic [31:0] latitude;
    logic [28:0] altitude_cm;
    logic [31:0] speed_abs;
    logic [31:0] speed_horiz;
    logic [22:0] heading;
    logic [31:0] vertical_speed;
    logic [7:0]  satellite_count;
  } result_t;

  function automatic slot_map_t slot_of(input logic [7:0] idx);
    slot_map_t m;
    m.hit  = 1'b0;
    m.slot = '0;
    if (idx < 8'd12) begin
      m.hit  = 1'b1;
      m.slot = idx[4:0];
    end else if (idx >= 8'd16 && idx < 8'd28) begin
      m.hit  = 1'b1;
      m.slot = slot_t'(idx - 8'd4);
    end else if (idx >= 8'd36 && idx < 8'd40) begin
      m.hit  = 1'b1;
      m.slot = slot_t'(idx - 8'd12);
    end else if (idx == 8'd47) begin
      m.hit  = 1'b1;
      m.slot = SLOT_SATS;
    end
    return m;
  endfunction

  function automatic logic [31:0] word_at(input cap_t cap, input slot_t s);
    return {cap[slot_t'(s + 5'd3)], cap[slot_t'(s + 5'd2)],
            cap[slot_t'(s + 5'd1)], cap[s]};
  endfunction

endpackage

/* rtl/unfp_frame_sync.sv */
// Frame sync, header capture, Fletcher sums and payload capture.
// Depends on unfp_pkg.
module unfp_frame_sync (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  input  logic [7:0]           data_byte,
  output unfp_pkg::frame_evt_t evt,
  output unfp_pkg::cap_t       cap
);

  localparam logic [3:0] ST_SYNC1   = 4'd0;
  localparam logic [3:0] ST_SYNC2   = 4'd1;
  localparam logic [3:0] ST_CLASS   = 4'd2;
  localparam logic [3:0] ST_ID      = 4'd3;
  localparam logic [3:0] ST_LEN_LO  = 4'd4;
  localparam logic [3:0] ST_LEN_HI  = 4'd5;
  localparam logic [3:0] ST_PAYLOAD = 4'd6;
  localparam logic [3:0] ST_CK_A    = 4'd7;
  localparam logic [3:0] ST_CK_B    = 4'd8;

  logic [3:0] step;
  logic [7:0] sum_a;
  logic [7:0] sum_b;
  logic [7:0] msg_class;
  logic [7:0] msg_id;
  logic [7:0] payload_len;
  logic [7:0] payload_count;
  logic [7:0] recv_sum_a;

  logic [7:0] acc_a;
  logic [7:0] acc_b;
  logic [7:0] count_inc;
  logic       cks_match;
  unfp_pkg::slot_map_t map;

  assign acc_a     = sum_a + data_byte;
  assign acc_b     = sum_b + acc_a;
  assign count_inc = payload_count + 8'd1;
  assign map       = unfp_pkg::slot_of(payload_count);
  assign cks_match = (sum_a == recv_sum_a) && (sum_b == data_byte);

  assign evt.len_err   = (step == ST_LEN_LO) && (data_byte >= unfp_pkg::MAX_PAYLOAD);
  assign evt.cks_ok    = (step == ST_CK_B) && cks_match;
  assign evt.cks_err   = (step == ST_CK_B) && !cks_match;
  assign evt.msg_class = msg_class;
  assign evt.msg_id    = msg_id;

  always_ff @(posedge clk) begin
    if (rst) begin
      step          <= ST_SYNC1;
      sum_a         <= '0;
      sum_b         <= '0;
      msg_class     <= '0;
      msg_id        <= '0;
      payload_len   <= '0;
      payload_count <= '0;
      recv_sum_a    <= '0;
      cap           <= '0;
    end else if (byte_valid) begin
      case (step)
        ST_SYNC1: begin
          if (data_byte == unfp_pkg::SYNC_1) step <= ST_SYNC2;
        end
        ST_SYNC2: begin
          step <= (data_byte == unfp_pkg::SYNC_2) ? ST_CLASS : ST_SYNC1;
        end
        ST_CLASS: begin
          msg_class <= data_byte;
          sum_a     <= acc_a;
          sum_b     <= acc_b;
          step      <= ST_ID;
        end
        ST_ID: begin
          msg_id <= data_byte;
          sum_a  <= acc_a;
          sum_b  <= acc_b;
          step   <= ST_LEN_LO;
        end
        ST_LEN_LO: begin
          payload_len <= data_byte;
          if (evt.len_err) begin
            sum_a <= '0;
            sum_b <= '0;
            step  <= ST_SYNC1;
          end else begin
            sum_a <= acc_a;
            sum_b <= acc_b;
            step  <= ST_LEN_HI;
          end
        end
        ST_LEN_HI: begin
          sum_a         <= acc_a;
          sum_b         <= acc_b;
          payload_count <= '0;
          step          <= (payload_len == 8'd0) ? ST_CK_A : ST_PAYLOAD;
        end
        ST_PAYLOAD: begin
          if (payload_count < payload_len) begin
            if (map.hit) cap[map.slot] <= data_byte;
            sum_a         <= acc_a;
            sum_b         <= acc_b;
            payload_count <= count_inc;
            if (count_inc >= payload_len) step <= ST_CK_A;
          end else begin
            step <= ST_CK_A;
          end
        end
        ST_CK_A: begin
          recv_sum_a <= data_byte;
          step       <= ST_CK_B;
        end
        ST_CK_B: begin
          sum_a <= '0;
          sum_b <= '0;
          step  <= ST_SYNC1;
        end
        default: begin
          step <= ST_SYNC1;
        end
      endcase
    end
  end

endmodule

/* rtl/unfp_nav_track.sv */
// Held navigation state, frame age and timeout, divide-by-constant stage.
// Depends on unfp_pkg; fed by unfp_frame_sync.
module unfp_nav_track (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic                 operation,
  input  unfp_pkg::frame_evt_t evt,
  input  unfp_pkg::cap_t       cap,
  input  logic                 cfg_wr_en,
  input  logic [15:0]          cfg_wr_data,
  output logic                 res_valid,
  output unfp_pkg::result_t    res
);

  localparam logic [31:0] DIV10_MUL   = 32'hCCCCCCCD;
  localparam logic [28:0] DIV1000_MUL = 29'h10624DD3;

  logic [15:0] timeout_ms;
  logic [15:0] ms_since_frame;
  logic        fix_flag;
  logic [31:0] tow;
  logic [31:0] lon;
  logic [31:0] lat;
  logic [28:0] alt;
  logic [31:0] spd3d;
  logic [31:0] gspd;
  logic [22:0] crs;
  logic [31:0] vz;
  logic [7:0]  sats;

  logic [15:0] ms_next;
  logic        fix_next;
  logic [31:0] tow_next;
  logic [31:0] lon_next;
  logic [31:0] lat_next;
  logic [28:0] alt_next;
  logic [31:0] spd3d_next;
  logic [31:0] gspd_next;
  logic [22:0] crs_next;
  logic [31:0] vz_next;
  logic [7:0]  sats_next;
  logic [2:0]  kind;
  logic [15:0] ms_inc;

  logic [31:0] word16;
  logic [31:0] word24;
  logic [31:0] mag16;
  logic [31:0] mag24;
  logic [63:0] prod_alt;
  logic [60:0] prod_crs;
  logic        neg_alt;
  logic        neg_crs;
  logic [28:0] alt_q;
  logic [22:0] crs_q;
  logic [28:0] alt_div;
  logic [22:0] crs_div;

  // Quotients settle in the cycle after the payload bytes land.
  assign word16 = unfp_pkg::word_at(cap, unfp_pkg::SLOT_P16);
  assign word24 = unfp_pkg::word_at(cap, unfp_pkg::SLOT_P24);
  assign mag16  = word16[31] ? (32'd0 - word16) : word16;
  assign mag24  = word24[31] ? (32'd0 - word24) : word24;

  always_ff @(posedge clk) begin
    prod_alt <= {32'd0, mag16} * {32'd0, DIV10_MUL};
    prod_crs <= {29'd0, mag24} * {32'd0, DIV1000_MUL};
    neg_alt  <= word16[31];
    neg_crs  <= word24[31];
  end

  assign alt_q   = prod_alt[63:35];
  assign crs_q   = prod_crs[60:38];
  assign alt_div = neg_alt ? (29'd0 - alt_q) : alt_q;
  assign crs_div = neg_crs ? (23'd0 - crs_q) : crs_q;

  assign ms_inc = (ms_since_frame != 16'hFFFF) ? (ms_since_frame + 16'd1) : ms_since_frame;

  always_comb begin
    ms_next    = ms_since_frame;
    fix_next   = fix_flag;
    tow_next   = tow;
    lon_next   = lon;
    lat_next   = lat;
    alt_next   = alt;
    spd3d_next = spd3d;
    gspd_next  = gspd;
    crs_next   = crs;
    vz_next    = vz;
    sats_next  = sats;
    kind       = unfp_pkg::KIND_POSITION;
    res_valid  = 1'b0;
    if (accept) begin
      if (operation == unfp_pkg::OP_TICK) begin
        ms_next = ms_inc;
        if (ms_since_frame <= timeout_ms && ms_inc > timeout_ms) begin
          fix_next  = 1'b0;
          kind      = unfp_pkg::KIND_TIMEOUT;
          res_valid = 1'b1;
        end
      end else begin
        if (evt.cks_ok || evt.cks_err) ms_next = '0;
        if (evt.len_err) begin
          kind      = unfp_pkg::KIND_LEN_ERR;
          res_valid = 1'b1;
        end else if (evt.cks_err) begin
          kind      = unfp_pkg::KIND_CKS_ERR;
          res_valid = 1'b1;
        end else if (evt.cks_ok && evt.msg_class == unfp_pkg::CLASS_NAV) begin
          case (evt.msg_id)
            unfp_pkg::ID_POSLLH: begin
              tow_next  = unfp_pkg::word_at(cap, unfp_pkg::SLOT_TOW);
              lon_next  = unfp_pkg::word_at(cap, unfp_pkg::SLOT_LON);
              lat_next  = unfp_pkg::word_at(cap, unfp_pkg::SLOT_LAT);
              alt_next  = alt_div;
              kind      = unfp_pkg::KIND_POSITION;
              res_valid = 1'b1;
            end
            unfp_pkg::ID_STATUS: begin
              fix_next  = (cap[unfp_pkg::SLOT_STAT_FIX] >= unfp_pkg::FIX_3D) &&
                          cap[unfp_pkg::SLOT_STAT_FLAGS][0];
              kind      = unfp_pkg::KIND_STATUS;
              res_valid = 1'b1;
            end
            unfp_pkg::ID_SOL: begin
              fix_next  = (cap[unfp_pkg::SLOT_SOL_FIX] >= unfp_pkg::FIX_3D) &&
                          cap[unfp_pkg::SLOT_SOL_FLAGS][0];
              vz_next   = unfp_pkg::word_at(cap, unfp_pkg::SLOT_P36);
              sats_next = cap[unfp_pkg::SLOT_SATS];
              kind      = unfp_pkg::KIND_SOLUTION;
              res_valid = 1'b1;
            end
            unfp_pkg::ID_VELNED: begin
              spd3d_next = word16;
              gspd_next  = unfp_pkg::word_at(cap, unfp_pkg::SLOT_P20);
              crs_next   = crs_div;
              kind       = unfp_pkg::KIND_VELOCITY;
              res_valid  = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  assign res.kind            = kind;
  assign res.fix_valid       = fix_next;
  assign res.time_of_week    = tow_next;
  assign res.longitude       = lon_next;
  assign res.latitude        = lat_next;
  assign res.altitude_cm     = alt_next;
  assign res.speed_abs       = spd3d_next;
  assign res.speed_horiz     = gspd_next;
  assign res.heading         = crs_next;
  assign res.vertical_speed  = vz_next;
  assign res.satellite_count = sats_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms     <= unfp_pkg::TIMEOUT_RESET;
      ms_since_frame <= '0;
      fix_flag       <= 1'b0;
      tow            <= '0;
      lon            <= '0;
      lat            <= '0;
      alt            <= '0;
      spd3d          <= '0;
      gspd           <= '0;
      crs            <= '0;
      vz             <= '0;
      sats           <= '0;
    end else begin
      if (cfg_wr_en) timeout_ms <= cfg_wr_data;
      ms_since_frame <= ms_next;
      fix_flag       <= fix_next;
      tow            <= tow_next;
      lon            <= lon_next;
      lat            <= lat_next;
      alt            <= alt_next;
      spd3d          <= spd3d_next;
      gspd           <= gspd_next;
      crs            <= crs_next;
      vz             <= vz_next;
      sats           <= sats_next;
    end
  end

endmodule

/* rtl/unfp_out_buf.sv */
// Output register with one skid entry for result words.
// Depends on unfp_pkg.
module unfp_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  unfp_pkg::result_t in_res,
  output logic              out_valid,
  input  logic              out_ready,
  output unfp_pkg::result_t out_res
);

  logic              skid_valid;
  unfp_pkg::result_t skid_res;

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
      end
    end else if (in_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      out_res <= skid_valid ? skid_res : in_res;
    end else if (in_valid) begin
      skid_res <= in_res;
    end
  end

endmodule

/* rtl/ubx_nav_frame_parser.sv */
// Top level of the binary navigation frame parser.
// Depends on unfp_pkg, unfp_frame_sync, unfp_nav_track and unfp_out_buf.
//
// Takes one word per clock while s_axis_tready is high: a received byte
// (tuser 0) or a millisecond tick (tuser 1). Frames start with 0xB5 0x62,
// carry class, id and a length byte below 64, and close with two Fletcher
// check bytes. A result word comes out of an output register backed by one
// skid entry; s_axis_tready drops only while both hold results. Every
// result carries the full held navigation state. The divide-by-10 and
// divide-by-1000 steps run through one registered multiply stage that trails
// payload capture, which the two check bytes always cover.
// timeout_ms resets to 2000 and is to be written through cfg_wr_en/cfg_wr_data
// by the user only while the block is idle; the block itself does not enforce this.
module ubx_nav_frame_parser (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,  // data_byte
  input  logic [0:0]   s_axis_tuser,  // operation
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // fix_valid, time_of_week, longitude, latitude, altitude_cm, speed_abs,
  // speed_horiz, heading, vertical_speed, satellite_count, zero pad
  output logic [255:0] m_axis_tdata,
  output logic [2:0]   m_axis_tuser,  // message_kind
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data
);

  logic                 accept;
  logic                 byte_valid;
  logic                 res_valid;
  unfp_pkg::frame_evt_t evt;
  unfp_pkg::cap_t       cap;
  unfp_pkg::result_t    res;
  unfp_pkg::result_t    out_res;

  assign accept     = s_axis_tvalid && s_axis_tready;
  assign byte_valid = accept && (s_axis_tuser[0] == unfp_pkg::OP_BYTE);

  unfp_frame_sync u_frame_sync (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .data_byte  (s_axis_tdata),
    .evt        (evt),
    .cap        (cap)
  );

  unfp_nav_track u_nav_track (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .operation   (s_axis_tuser[0]),
    .evt         (evt),
    .cap         (cap),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .res_valid   (res_valid),
    .res         (res)
  );

  unfp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_ready  (s_axis_tready),
    .in_res    (res),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  assign m_axis_tuser = out_res.kind;
  assign m_axis_tdata = {3'd0,
                         out_res.satellite_count,
                         out_res.vertical_speed,
                         out_res.heading,
                         out_res.speed_horiz,
                         out_res.speed_abs,
                         out_res.altitude_cm,
                         out_res.latitude,
                         out_res.longitude,
                         out_res.time_of_week,
                         out_res.fix_valid};

endmodule

/* dv/tb_ubx_nav_frame_parser.sv */
// Testbench for ubx_nav_frame_parser: drives byte and tick words, predicts each result
// word with its own frame parser, and compares every result word field by field.
// Depends on unfp_pkg and the rtl sources; needs no files or arguments.
module tb_ubx_nav_frame_parser;
  import unfp_pkg::*;

  typedef enum logic [3:0] {
    HUNT_SYNC1, HUNT_SYNC2, GET_CLASS, GET_ID, GET_LEN, GET_LEN_HI,
    GET_PAYLOAD, GET_CK_A, GET_CK_B
  } parse_state_t;

  typedef enum {FLOW_FREE, FLOW_SRC_IDLE, FLOW_SNK_STALL, FLOW_BOTH} flow_t;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
    logic [3:0] exp_kind;
  } dir_row_t;

  localparam logic [3:0] FROM_PREDICTOR = 4'hF;
  localparam int HOLD_CYCLES = 300;

  localparam dir_row_t DIRECTED_ROWS [26] = '{
    '{OP_TICK, 8'h00, FROM_PREDICTOR},
    '{OP_TICK, 8'hFF, {1'b0, KIND_TIMEOUT}},
    '{OP_BYTE, SYNC_1, FROM_PREDICTOR},
    '{OP_BYTE, SYNC_2, FROM_PREDICTOR},
    '{OP_BYTE, CLASS_NAV, FROM_PREDICTOR},
    '{OP_BYTE, ID_POSLLH, FROM_PREDICTOR},
    '{OP_BYTE, MAX_PAYLOAD, {1'b0, KIND_LEN_ERR}},
    '{OP_BYTE, SYNC_1, FROM_PREDICTOR},
    '{OP_BYTE, 8'h00, FROM_PREDICTOR},
    '{OP_BYTE, SYNC_1, FROM_PREDICTOR},
    '{OP_BYTE, SYNC_2, FROM_PREDICTOR},
    '{OP_BYTE, CLASS_NAV, FROM_PREDICTOR},
    '{OP_BYTE, ID_STATUS, FROM_PREDICTOR},
    '{OP_BYTE, 8'h00, FROM_PREDICTOR},
    '{OP_BYTE, 8'h00, FROM_PREDICTOR},
    '{OP_BYTE, 8'h04, FROM_PREDICTOR},
    '{OP_BYTE, 8'h00, {1'b0, KIND_CKS_ERR}},
    '{OP_BYTE, SYNC_1, FROM_PREDICTOR},
    '{OP_BYTE, SYNC_2, FROM_PREDICTOR},
    '{OP_BYTE, CLASS_NAV, FROM_PREDICTOR},
    '{OP_BYTE, ID_VELNED, FROM_PREDICTOR},
    '{OP_BYTE, 8'h01, FROM_PREDICTOR},
    '{OP_BYTE, 8'h00, FROM_PREDICTOR},
    '{OP_BYTE, 8'hFF, FROM_PREDICTOR},
    '{OP_BYTE, 8'h13, FROM_PREDICTOR},
    '{OP_BYTE, 8'h4F, FROM_PREDICTOR}
  };

  localparam logic [15:0] PHASE_TIMEOUTS [4] = '{16'd20, 16'd300, 16'd1, 16'd5};

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = 8'h00;
  logic [0:0]   s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [255:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;
  logic         cfg_wr_en = 1'b0;
  logic [15:0]  cfg_wr_data = 16'h0000;

  int  gap_pct = 0;
  int  stall_pct = 0;
  logic hold_active = 1'b0;
  event start_hold;
  int  words_accepted = 0;
  int  mismatches = 0;
  result_t nav_reports_due[$];

  logic [15:0]  timeout_val = TIMEOUT_RESET;
  parse_state_t parse_state = HUNT_SYNC1;
  logic [7:0]   ck_a = 8'h00, ck_b = 8'h00, rx_ck_a = 8'h00;
  logic [7:0]   frm_class = 8'h00, frm_id = 8'h00, frm_len = 8'h00, frm_count = 8'h00;
  logic [7:0]   held_payload [64] = '{default: 8'h00};
  logic         fix_held = 1'b0;
  logic [31:0]  tow_held = '0, lon_held = '0, lat_held = '0, alt_held = '0;
  logic [31:0]  spd3d_held = '0, gspd_held = '0, course_held = '0, vz_held = '0;
  logic [7:0]   sats_held = 8'h00;
  logic [15:0]  frame_age = 16'h0000;

  ubx_nav_frame_parser dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  always #10 clk = ~clk;

  function automatic void fletcher_add(input logic [7:0] b);
    ck_a = ck_a + b;
    ck_b = ck_b + ck_a;
  endfunction

  function automatic logic [31:0] payload_word(input int i);
    return {held_payload[i+3], held_payload[i+2], held_payload[i+1], held_payload[i]};
  endfunction

  function automatic logic [31:0] div_to_zero(input logic [31:0] w, input int d);
    return 32'($signed(w) / d);
  endfunction

  function automatic result_t nav_report(input logic [2:0] kind);
    result_t r;
    r.kind            = kind;
    r.fix_valid       = fix_held;
    r.time_of_week    = tow_held;
    r.longitude       = lon_held;
    r.latitude        = lat_held;
    r.altitude_cm     = alt_held[28:0];
    r.speed_abs       = spd3d_held;
    r.speed_horiz     = gspd_held;
    r.heading         = course_held[22:0];
    r.vertical_speed  = vz_held;
    r.satellite_count = sats_held;
    return r;
  endfunction

  function automatic bit decode_frame(output result_t rep);
    bit produced;
    produced = 1'b0;
    rep = '0;
    if (frm_class == CLASS_NAV) begin
      case (frm_id)
        ID_POSLLH: begin
          tow_held = payload_word(0);
          lon_held = payload_word(4);
          lat_held = payload_word(8);
          alt_held = div_to_zero(payload_word(16), 10);
          rep = nav_report(KIND_POSITION);
          produced = 1'b1;
        end
        ID_STATUS: begin
          fix_held = (held_payload[4] >= FIX_3D) && held_payload[5][0];
          rep = nav_report(KIND_STATUS);
          produced = 1'b1;
        end
        ID_SOL: begin
          fix_held = (held_payload[10] >= FIX_3D) && held_payload[11][0];
          vz_held = payload_word(36);
          sats_held = held_payload[47];
          rep = nav_report(KIND_SOLUTION);
          produced = 1'b1;
        end
        ID_VELNED: begin
          spd3d_held = payload_word(16);
          gspd_held = payload_word(20);
          course_held = div_to_zero(payload_word(24), 1000);
          rep = nav_report(KIND_VELOCITY);
          produced = 1'b1;
        end
        default: produced = 1'b0;
      endcase
    end
    return produced;
  endfunction

  function automatic bit parse_word(input logic op, input logic [7:0] b, output result_t rep);
    logic [15:0] prev_age;
    bit produced;
    produced = 1'b0;
    rep = '0;
    if (op == OP_TICK) begin
      prev_age = frame_age;
      if (frame_age != 16'hFFFF) frame_age = frame_age + 16'd1;
      if (prev_age <= timeout_val && frame_age > timeout_val) begin
        fix_held = 1'b0;
        rep = nav_report(KIND_TIMEOUT);
        produced = 1'b1;
      end
    end else begin
      case (parse_state)
        HUNT_SYNC1: if (b == SYNC_1) parse_state = HUNT_SYNC2;
        HUNT_SYNC2: parse_state = (b == SYNC_2) ? GET_CLASS : HUNT_SYNC1;
        GET_CLASS: begin
          frm_class = b;
          fletcher_add(b);
          parse_state = GET_ID;
        end
        GET_ID: begin
          frm_id = b;
          fletcher_add(b);
          parse_state = GET_LEN;
        end
        GET_LEN: begin
          frm_len = b;
          fletcher_add(b);
          if (b >= MAX_PAYLOAD) begin
            parse_state = HUNT_SYNC1;
            ck_a = 8'h00;
            ck_b = 8'h00;
            rep = nav_report(KIND_LEN_ERR);
            produced = 1'b1;
          end else begin
            parse_state = GET_LEN_HI;
          end
        end
        GET_LEN_HI: begin
          fletcher_add(b);
          frm_count = 8'h00;
          parse_state = (frm_len == 8'h00) ? GET_CK_A : GET_PAYLOAD;
        end
        GET_PAYLOAD: begin
          if (frm_count < frm_len) begin
            held_payload[frm_count] = b;
            fletcher_add(b);
            frm_count = frm_count + 8'd1;
          end
          if (frm_count >= frm_len) parse_state = GET_CK_A;
        end
        GET_CK_A: begin
          rx_ck_a = b;
          parse_state = GET_CK_B;
        end
        GET_CK_B: begin
          if (ck_a == rx_ck_a && ck_b == b) begin
            produced = decode_frame(rep);
          end else begin
            rep = nav_report(KIND_CKS_ERR);
            produced = 1'b1;
          end
          parse_state = HUNT_SYNC1;
          ck_a = 8'h00;
          ck_b = 8'h00;
          frame_age = 16'h0000;
        end
        default: parse_state = HUNT_SYNC1;
      endcase
    end
    return produced;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic send_word(input logic op, input logic [7:0] b,
                           input logic [3:0] typed_kind = FROM_PREDICTOR);
    result_t rep;
    bit produced;
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    words_accepted++;
    produced = parse_word(op, b, rep);
    if (typed_kind != FROM_PREDICTOR) begin
      rep = '0;
      rep.kind = typed_kind[2:0];
      produced = 1'b1;
    end
    if (produced) nav_reports_due.push_back(rep);
  endtask

  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < 3) send_word(OP_TICK, 8'($urandom));
    send_word(OP_BYTE, b);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_word(OP_TICK, 8'($urandom));
  endtask

  task automatic send_frame(input logic [7:0] cls, input logic [7:0] mid, input logic [7:0] len,
                            input bit bad_ck, input int cut);
    logic [7:0]  words[$];
    logic [7:0]  a, b, hi, x;
    logic [31:0] ext;
    int at;
    hi = ($urandom_range(3) == 0) ? 8'($urandom) : 8'h00;
    words = '{SYNC_1, SYNC_2, cls, mid, len, hi};
    if (len < MAX_PAYLOAD) begin
      for (int i = 0; i < int'(len); i++) begin
        x = 8'($urandom);
        if ((i == 4 || i == 10) && $urandom_range(1) == 1) x = 8'($urandom_range(5));
        words.push_back(x);
      end
      if (len >= 8'd28 && $urandom_range(9) == 0) begin
        case ($urandom_range(3))
          0: ext = 32'h8000_0000;
          1: ext = 32'h7FFF_FFFF;
          2: ext = 32'hFFFF_FFFF;
          default: ext = 32'd9;
        endcase
        at = ($urandom_range(1) == 1) ? 22 : 30;
        for (int k = 0; k < 4; k++) words[at+k] = ext[8*k +: 8];
      end
      a = 8'h00;
      b = 8'h00;
      for (int i = 2; i < words.size(); i++) begin
        a = a + words[i];
        b = b + a;
      end
      if (bad_ck) begin
        if ($urandom_range(1) == 1) a = a ^ 8'($urandom_range(1, 255));
        else b = b ^ 8'($urandom_range(1, 255));
      end
      words.push_back(a);
      words.push_back(b);
    end
    if (cut < 0 || cut > words.size()) cut = words.size();
    for (int i = 0; i < cut; i++) send_byte(words[i]);
  endtask

  task automatic send_random_frame();
    logic [7:0] cls, mid, len;
    int pick;
    pick = $urandom_range(99);
    case ($urandom_range(3))
      0: begin mid = ID_POSLLH; len = 8'd28; end
      1: begin mid = ID_STATUS; len = 8'd16; end
      2: begin mid = ID_SOL;    len = 8'd52; end
      default: begin mid = ID_VELNED; len = 8'd36; end
    endcase
    cls = CLASS_NAV;
    if (pick < 8) begin
      if ($urandom_range(2) == 0) send_word(OP_BYTE, SYNC_1);
      repeat ($urandom_range(1, 6)) send_word(1'($urandom_range(1)), 8'($urandom));
    end else begin
      if (pick < 16) begin
        cls = 8'($urandom);
        mid = 8'($urandom);
      end else if (pick < 30) begin
        len = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(63));
      end else if (pick < 37) begin
        len = 8'($urandom_range(64, 255));
      end
      send_frame(cls, mid, len, $urandom_range(99) < 12,
                 (pick >= 37 && pick < 43) ? int'($urandom_range(2, 40)) : -1);
    end
    if ($urandom_range(3) == 0) send_ticks($urandom_range(1, 3));
    if ($urandom_range(19) == 0) send_ticks($urandom_range(1, 40));
  endtask

  task automatic drain_reports();
    s_axis_tvalid <= 1'b0;
    while (nav_reports_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic program_timeout(input logic [15:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    timeout_val = v;
  endtask

  task automatic set_flow(input flow_t f);
    gap_pct   = (f == FLOW_SRC_IDLE) ? 79 : (f == FLOW_BOTH) ? 30 : 0;
    stall_pct = (f == FLOW_SNK_STALL) ? 79 : (f == FLOW_BOTH) ? 30 : 0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !hold_active && ($urandom_range(99) >= stall_pct);
    end
  end

  always begin
    @(start_hold);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active <= 1'b0;
  end

  always @(posedge clk) begin
    result_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.kind            = m_axis_tuser;
      got.fix_valid       = m_axis_tdata[0];
      got.time_of_week    = m_axis_tdata[32:1];
      got.longitude       = m_axis_tdata[64:33];
      got.latitude        = m_axis_tdata[96:65];
      got.altitude_cm     = m_axis_tdata[125:97];
      got.speed_abs       = m_axis_tdata[157:126];
      got.speed_horiz     = m_axis_tdata[189:158];
      got.heading         = m_axis_tdata[212:190];
      got.vertical_speed  = m_axis_tdata[244:213];
      got.satellite_count = m_axis_tdata[252:245];
      if (nav_reports_due.size() == 0) begin
        $error("result word with none expected, kind %0d", got.kind);
        mismatches++;
      end else begin
        want = nav_reports_due.pop_front();
        check_field("message_kind", 32'(want.kind), 32'(got.kind));
        check_field("fix_valid", 32'(want.fix_valid), 32'(got.fix_valid));
        check_field("time_of_week", want.time_of_week, got.time_of_week);
        check_field("longitude", want.longitude, got.longitude);
        check_field("latitude", want.latitude, got.latitude);
        check_field("altitude_cm", 32'(want.altitude_cm), 32'(got.altitude_cm));
        check_field("speed_abs", want.speed_abs, got.speed_abs);
        check_field("speed_horiz", want.speed_horiz, got.speed_horiz);
        check_field("heading", 32'(want.heading), 32'(got.heading));
        check_field("vertical_speed", want.vertical_speed, got.vertical_speed);
        check_field("satellite_count", 32'(want.satellite_count), 32'(got.satellite_count));
      end
    end
  end

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int phase_start;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_flow(FLOW_FREE);
    program_timeout(16'd1);
    foreach (DIRECTED_ROWS[i]) begin
      send_word(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].exp_kind);
    end
    drain_reports();

    for (int p = 0; p < 4; p++) begin
      set_flow(flow_t'(p));
      program_timeout(PHASE_TIMEOUTS[p]);
      phase_start = words_accepted;
      while (words_accepted - phase_start < 500) send_random_frame();
      if (p == 0) begin
        // hold the receiver and flood length errors so the output side backs up
        -> start_hold;
        repeat (12) begin
          send_word(OP_BYTE, SYNC_1);
          send_word(OP_BYTE, SYNC_2);
          send_word(OP_BYTE, CLASS_NAV);
          send_word(OP_BYTE, ID_POSLLH);
          send_word(OP_BYTE, 8'hFF);
        end
      end
      drain_reports();
    end

    // age the last frame under a high timeout, then lower it: neither may fire
    set_flow(FLOW_FREE);
    program_timeout(16'hFFFF);
    send_ticks(60);
    drain_reports();
    program_timeout(16'd1);
    send_ticks(4);
    send_frame(CLASS_NAV, ID_SOL, 8'd52, 1'b0, -1);
    send_ticks(3);

    s_axis_tvalid <= 1'b0;
    for (int i = 0; i < 5000 && nav_reports_due.size() != 0; i++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (nav_reports_due.size() != 0) begin
      $error("%0d expected result words never arrived", nav_reports_due.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* ubx_nav_frame_parser.f */
rtl/unfp_pkg.sv
rtl/unfp_frame_sync.sv
rtl/unfp_nav_track.sv
rtl/unfp_out_buf.sv
rtl/ubx_nav_frame_parser.sv
dv/tb_ubx_nav_frame_parser.sv
